/* rtl/hbd_pkg.sv */
package hbd_pkg;

	// Default width of the chunk size accumulator and byte counter
	localparam int SIZE_BITS_DEF = 31;

	// Configuration port
	localparam int CFG_DATA_W = 31;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNKED_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH  = 1'b1;

	// Input request codes
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_BYTE  = 1'b1;

	// Line delimiters
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// Classification of one stream byte
	typedef struct packed {
		logic       is_cr;
		logic       is_lf;
		logic       is_hex;
		logic [3:0] hex_val;
	} byte_class_t;

endpackage

/* rtl/http_body_dechunker_top.sv */
// A result is registered and presented on out_valid in the cycle after its input transaction.
// Throughput: one input byte per cycle, set by the single result register; in_stall
// rises only while that register holds a result and out_stall is high.
// Reset (arst_n low, asynchronous): phase idle, size and byte counters zero,
// chunked_mode and body_length zero, result register empty.
module http_body_dechunker_top #(
	parameter int SIZE_BITS = hbd_pkg::SIZE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [hbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hbd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            req_type,
	input  logic [7:0]                      data_byte,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      result_kind,
	output logic [7:0]                      body_byte,
	output logic                            body_end
);

	logic                 chunked_mode_q;
	logic [30:0]          body_length_q;
	logic                 in_fire;
	logic                 out_take;
	hbd_pkg::byte_class_t cls;
	hbd_pkg::kind_t       res_kind;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_mode_q <= 1'b0;
			body_length_q  <= 31'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hbd_pkg::CFG_CHUNKED_MODE: chunked_mode_q <= cfg_data[0];
				hbd_pkg::CFG_BODY_LENGTH:  body_length_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Handshake: accept whenever the result slot is empty or being drained
	assign in_stall = out_valid && out_stall;
	assign in_fire  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	hbd_byte_class u_class (
		.data_byte (data_byte),
		.cls       (cls)
	);

	hbd_fsm #(
		.SIZE_BITS (SIZE_BITS)
	) u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.out_take     (out_take),
		.req_type     (req_type),
		.data_byte    (data_byte),
		.cls          (cls),
		.chunked_mode (chunked_mode_q),
		.body_length  (body_length_q),
		.res_valid_q  (out_valid),
		.res_kind_q   (res_kind),
		.res_byte_q   (body_byte),
		.res_end_q    (body_end)
	);

	assign result_kind = res_kind;

endmodule

/* rtl/hbd_byte_class.sv */
module hbd_byte_class (
	input  logic [7:0]          data_byte,
	output hbd_pkg::byte_class_t cls
);

	// Delimiter and hex digit decode
	always_comb begin
		cls.is_cr   = (data_byte == hbd_pkg::CHAR_CR);
		cls.is_lf   = (data_byte == hbd_pkg::CHAR_LF);
		cls.is_hex  = 1'b0;
		cls.hex_val = 4'd0;
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = data_byte[3:0];
		end else if ((data_byte >= 8'h41 && data_byte <= 8'h46) ||
		             (data_byte >= 8'h61 && data_byte <= 8'h66)) begin
			// A-F and a-f share the low nibble 1..6
			cls.is_hex  = 1'b1;
			cls.hex_val = data_byte[3:0] + 4'd9;
		end
	end

endmodule

/* rtl/hbd_fsm.sv */
module hbd_fsm #(
	parameter int SIZE_BITS = hbd_pkg::SIZE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_fire,
	input  logic                  out_take,
	input  logic                  req_type,
	input  logic [7:0]            data_byte,
	input  hbd_pkg::byte_class_t  cls,
	input  logic                  chunked_mode,
	input  logic [30:0]           body_length,
	output logic                  res_valid_q,
	output hbd_pkg::kind_t        res_kind_q,
	output logic [7:0]            res_byte_q,
	output logic                  res_end_q
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_LEN,
		PH_SIZE,
		PH_SIZE_LF,
		PH_DATA,
		PH_DATA_CR,
		PH_DATA_LF,
		PH_ZERO_CR,
		PH_ZERO_LF
	} phase_t;

	localparam logic [SIZE_BITS-1:0] ONE  = {{(SIZE_BITS-1){1'b0}}, 1'b1};
	localparam logic [SIZE_BITS-1:0] ZERO = '0;

	phase_t               phase_q, phase_d;
	logic [SIZE_BITS-1:0] acc_q, acc_d;
	logic [SIZE_BITS-1:0] left_q, left_d;
	logic [SIZE_BITS-1:0] left_dec;
	logic [SIZE_BITS-1:0] len_ext;
	logic [SIZE_BITS+30:0] len_wide;
	logic                 acc_ovf;
	logic                 emit;
	hbd_pkg::kind_t       kind_d;
	logic [7:0]           byte_d;
	logic                 end_d;

	// Body length fitted to the counter width
	assign len_wide = {{SIZE_BITS{1'b0}}, body_length};
	assign len_ext  = len_wide[SIZE_BITS-1:0];
	assign left_dec = left_q - ONE;
	// Another digit overflows when the top nibble is already in use
	assign acc_ovf  = (acc_q[SIZE_BITS-1 -: 4] != 4'd0);

	// Next state and result for the accepted item
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		left_d  = left_q;
		emit    = 1'b0;
		kind_d  = hbd_pkg::KIND_DATA;
		byte_d  = 8'd0;
		end_d   = 1'b0;
		if (req_type == hbd_pkg::REQ_START) begin
			acc_d  = ZERO;
			left_d = ZERO;
			if (chunked_mode) begin
				phase_d = PH_SIZE;
			end else if (body_length == 31'd0) begin
				phase_d = PH_IDLE;
				emit    = 1'b1;
				kind_d  = hbd_pkg::KIND_DONE;
				end_d   = 1'b1;
			end else begin
				left_d  = len_ext;
				phase_d = PH_LEN;
			end
		end else begin
			unique case (phase_q)
				PH_LEN: begin
					left_d = left_dec;
					emit   = 1'b1;
					byte_d = data_byte;
					if (left_dec == ZERO) begin
						phase_d = PH_IDLE;
						end_d   = 1'b1;
					end
				end
				PH_SIZE: begin
					if (cls.is_cr) begin
						phase_d = PH_SIZE_LF;
					end else if (!cls.is_hex || acc_ovf) begin
						phase_d = PH_IDLE;
						emit    = 1'b1;
						kind_d  = hbd_pkg::KIND_ERROR;
					end else begin
						acc_d = {acc_q[SIZE_BITS-5:0], cls.hex_val};
					end
				end
				PH_SIZE_LF: begin
					if (!cls.is_lf) begin
						phase_d = PH_IDLE;
						emit    = 1'b1;
						kind_d  = hbd_pkg::KIND_ERROR;
					end else begin
						if (acc_q == ZERO) begin
							phase_d = PH_ZERO_CR;
						end else begin
							left_d  = acc_q;
							phase_d = PH_DATA;
						end
						acc_d = ZERO;
					end
				end
				PH_DATA: begin
					left_d = left_dec;
					emit   = 1'b1;
					byte_d = data_byte;
					if (left_dec == ZERO) begin
						phase_d = PH_DATA_CR;
					end
				end
				PH_DATA_CR, PH_ZERO_CR: begin
					if (!cls.is_cr) begin
						phase_d = PH_IDLE;
						emit    = 1'b1;
						kind_d  = hbd_pkg::KIND_ERROR;
					end else begin
						phase_d = (phase_q == PH_DATA_CR) ? PH_DATA_LF : PH_ZERO_LF;
					end
				end
				PH_DATA_LF: begin
					if (!cls.is_lf) begin
						phase_d = PH_IDLE;
						emit    = 1'b1;
						kind_d  = hbd_pkg::KIND_ERROR;
					end else begin
						acc_d   = ZERO;
						phase_d = PH_SIZE;
					end
				end
				PH_ZERO_LF: begin
					phase_d = PH_IDLE;
					emit    = 1'b1;
					if (!cls.is_lf) begin
						kind_d = hbd_pkg::KIND_ERROR;
					end else begin
						kind_d = hbd_pkg::KIND_DONE;
						end_d  = 1'b1;
					end
				end
				default: begin
					// stray byte while idle
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			acc_q       <= ZERO;
			left_q      <= ZERO;
			res_valid_q <= 1'b0;
			res_kind_q  <= hbd_pkg::KIND_DATA;
			res_byte_q  <= 8'd0;
			res_end_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q     <= phase_d;
				acc_q       <= acc_d;
				left_q      <= left_d;
				res_valid_q <= emit;
				res_kind_q  <= kind_d;
				res_byte_q  <= byte_d;
				res_end_q   <= end_d;
			end else if (out_take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/hbd_checker.sv */
module hbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] result_kind,
	input logic [7:0] body_byte,
	input logic       body_end
);

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind) &&
		$stable(body_byte) && $stable(body_end))
		else $error("stalled result changed");

	// Input is held back only by a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without backpressure");

	// Errors carry no byte and never end the body
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == hbd_pkg::KIND_ERROR |-> !body_end && body_byte == 8'd0)
		else $error("malformed error result");

	// Completion without data always ends the body and carries no byte
	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == hbd_pkg::KIND_DONE |-> body_end && body_byte == 8'd0)
		else $error("malformed completion result");

	// Only the three defined result kinds appear
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_kind == hbd_pkg::KIND_DATA ||
		result_kind == hbd_pkg::KIND_DONE || result_kind == hbd_pkg::KIND_ERROR)
		else $error("undefined result kind");

endmodule

bind http_body_dechunker_top hbd_checker u_hbd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_kind (result_kind),
	.body_byte   (body_byte),
	.body_end    (body_end)
);
